@@ hw/rtl/att_pkg.sv @@
// att_pkg: shared types and constants for the allocation tracking table
// used by att_table, att_alu and allocation_tracking_table; no dependencies
`default_nettype none

package att_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int ADDR_W   = 64;
    localparam int SIZE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 36;
    localparam int LIVE_W   = 5;

    // stream payload widths, padded to whole bytes
    localparam int S_BITS   = 1 + ADDR_W + SIZE_W;
    localparam int S_DATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_BITS   = STATUS_W + ADDR_W + TOTAL_W + LIVE_W;
    localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REMOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // one table entry
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } entry_t;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic clear;
        logic acc_en;
    } alu_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/att_table.sv @@
// att_table: entry storage, one write port and one registered read port
// depends on att_pkg for the entry type and table depth
`default_nettype none

module att_table (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [att_pkg::IDX_W-1:0] wr_idx,
    input  wire att_pkg::entry_t       wr_data,
    input  wire logic                  rd_en,
    input  wire logic [att_pkg::IDX_W-1:0] rd_idx,
    output att_pkg::entry_t            rd_data
);
    import att_pkg::*;

    entry_t mem [TABLE_DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_idx];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/att_alu.sv @@
// att_alu: shared scan unit, address match plus running max and byte sum
// depends on att_pkg for widths and the control struct
`default_nettype none

module att_alu (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire att_pkg::alu_ctl_t        ctl,
    input  wire logic [att_pkg::ADDR_W-1:0] key_addr,
    input  wire att_pkg::entry_t          entry,
    output logic                          match,
    output logic [att_pkg::ADDR_W-1:0]    best_addr,
    output logic [att_pkg::TOTAL_W-1:0]   total
);
    import att_pkg::*;

    logic [SIZE_W-1:0]  best_size_reg, best_size_next;
    logic [ADDR_W-1:0]  best_addr_reg, best_addr_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // address compare for the delete search
    assign match = (entry.addr == key_addr);

    // running max (later, newer entries win ties) and byte sum
    always_comb begin
        best_size_next = best_size_reg;
        best_addr_next = best_addr_reg;
        total_next     = total_reg;
        if (ctl.clear) begin
            best_size_next = '0;
            best_addr_next = '0;
            total_next     = '0;
        end else if (ctl.acc_en) begin
            if (entry.size >= best_size_reg) begin
                best_size_next = entry.size;
                best_addr_next = entry.addr;
            end
            total_next = total_reg + TOTAL_W'(entry.size);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_size_reg <= '0;
            best_addr_reg <= '0;
            total_reg     <= '0;
        end else begin
            best_size_reg <= best_size_next;
            best_addr_reg <= best_addr_next;
            total_reg     <= total_next;
        end
    end

    assign best_addr = best_addr_reg;
    assign total     = total_reg;

endmodule

`default_nettype wire

@@ hw/rtl/allocation_tracking_table.sv @@
// allocation_tracking_table: top level, sequencer and result register
// depends on att_pkg, att_table and att_alu
//
// usage: each s_ transaction carries one operation (insert or delete by
// address); each one yields exactly one m_ transaction with the status, the
// address of the largest live block, the total bytes held and the entry count.
// entries are kept oldest first in a 16-entry table; the sequencer walks it
// one entry per cycle through a single read port and one shared scan unit.
// an insert appends the entry at the newest end and then sums the live
// entries; when the table is full the insert is dropped and only the sum
// runs. a delete searches from the newest entry, moves the newer entries
// down over the freed slot and then sums; a delete that misses searches
// every live entry before the sum.
// s_tready is high only while the block is idle, so one item is in work at a
// time. the result sits in an output register; a stalled m_tready holds it
// and the next item may still be accepted, but its result waits until the
// previous one has been taken. reset empties the table and drops any
// pending result; the table storage itself is not cleared.
`default_nettype none

module allocation_tracking_table (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // s_tdata fields, low bit up: operation, block_address, block_size
    input  wire logic [att_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // m_tdata fields, low bit up: status, largest_block_address,
    // total_bytes, live_entries
    output logic [att_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready
);
    import att_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_INS   = 6'b000010,
        ST_FIND  = 6'b000100,
        ST_SHIFT = 6'b001000,
        ST_SUM   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   key_addr_reg, key_addr_next;
    logic [SIZE_W-1:0]   key_size_reg, key_size_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    iss_reg, iss_next;
    logic                pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_BITS-1:0]   m_data_reg, m_data_next;

    logic                in_op;
    logic [ADDR_W-1:0]   in_addr;
    logic [SIZE_W-1:0]   in_size;
    logic                s_fire;
    logic [CNT_W-1:0]    iss_m1;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    entry_t              wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_idx;
    entry_t              rd_data;

    alu_ctl_t            alu_ctl;
    logic                match;
    logic [ADDR_W-1:0]   best_addr;
    logic [TOTAL_W-1:0]  total;

    // input field unpacking
    assign in_op   = s_tdata[0];
    assign in_addr = s_tdata[ADDR_W:1];
    assign in_size = s_tdata[ADDR_W+SIZE_W:ADDR_W+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign iss_m1   = iss_reg - CNT_W'(1);

    // read issue: search runs newest to oldest, shift and sum run upward
    always_comb begin
        rd_en  = 1'b0;
        rd_idx = '0;
        unique case (state_reg)
            ST_FIND: begin
                rd_en  = (iss_reg != '0);
                rd_idx = iss_m1[IDX_W-1:0];
            end
            ST_SHIFT, ST_SUM: begin
                rd_en  = (iss_reg < count_reg);
                rd_idx = iss_reg[IDX_W-1:0];
            end
            default: begin
                rd_en  = 1'b0;
                rd_idx = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        key_addr_next = key_addr_reg;
        key_size_next = key_size_reg;
        count_next    = count_reg;
        iss_next      = iss_reg;
        pend_vld_next = rd_en;
        pend_idx_next = rd_idx;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        wr_idx        = '0;
        wr_data       = '0;
        alu_ctl       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    key_addr_next = in_addr;
                    key_size_next = in_size;
                    if (in_op == OP_INSERT) begin
                        if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            status_next   = STAT_FULL;
                            iss_next      = '0;
                            alu_ctl.clear = 1'b1;
                            state_next    = ST_SUM;
                        end else begin
                            state_next = ST_INS;
                        end
                    end else begin
                        iss_next   = count_reg;
                        state_next = ST_FIND;
                    end
                end
            end

            // append the new entry at the newest end
            ST_INS: begin
                wr_en         = 1'b1;
                wr_idx        = count_reg[IDX_W-1:0];
                wr_data.addr  = key_addr_reg;
                wr_data.size  = key_size_reg;
                count_next    = count_reg + CNT_W'(1);
                status_next   = STAT_INSERTED;
                iss_next      = '0;
                alu_ctl.clear = 1'b1;
                state_next    = ST_SUM;
            end

            // search newest first for a matching address
            ST_FIND: begin
                if (rd_en) begin
                    iss_next = iss_m1;
                end
                if (pend_vld_reg && match) begin
                    status_next   = STAT_REMOVED;
                    iss_next      = CNT_W'(pend_idx_reg) + CNT_W'(1);
                    pend_vld_next = 1'b0;
                    state_next    = ST_SHIFT;
                end else if (!pend_vld_reg && !rd_en) begin
                    status_next   = STAT_NOT_FOUND;
                    iss_next      = '0;
                    alu_ctl.clear = 1'b1;
                    state_next    = ST_SUM;
                end
            end

            // move newer entries down over the removed slot
            ST_SHIFT: begin
                if (rd_en) begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (pend_vld_reg) begin
                    wr_en   = 1'b1;
                    wr_idx  = pend_idx_reg - IDX_W'(1);
                    wr_data = rd_data;
                end
                if (!pend_vld_reg && !rd_en) begin
                    count_next    = count_reg - CNT_W'(1);
                    iss_next      = '0;
                    alu_ctl.clear = 1'b1;
                    state_next    = ST_SUM;
                end
            end

            // largest block and byte total over the live entries
            ST_SUM: begin
                if (rd_en) begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                alu_ctl.acc_en = pend_vld_reg;
                if (!pend_vld_reg && !rd_en) begin
                    state_next = ST_DONE;
                end
            end

            // load the result register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {LIVE_W'(count_reg), total, best_addr, status_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            iss_reg      <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            iss_reg      <= iss_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_addr_reg <= key_addr_next;
        key_size_reg <= key_size_next;
        pend_idx_reg <= pend_idx_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
    end

    att_table u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    att_alu u_alu (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (alu_ctl),
        .key_addr  (key_addr_reg),
        .entry     (rd_data),
        .match     (match),
        .best_addr (best_addr),
        .total     (total)
    );

    // result channel, zero padded to whole bytes
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// tb: self-checking bench for allocation_tracking_table, driving insert and delete
// transactions and checking status, largest block, byte total and entry count
// depends on att_pkg and the allocation_tracking_table rtl
`timescale 1ns / 1ps

module tb;
    import att_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AT     = 600;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   largest_addr;
        logic [TOTAL_W-1:0]  total_bytes;
        logic [LIVE_W-1:0]   live_entries;
    } alloc_result_t;

    // mirror of the allocation table plus the queue of predicted results
    class alloc_scoreboard;
        logic [ADDR_W-1:0] live_addr [TABLE_DEPTH];
        logic [SIZE_W-1:0] live_size [TABLE_DEPTH];
        int unsigned live_count = 0;
        alloc_result_t expected_results [$];
        int unsigned errors = 0;
        int unsigned results_seen = 0;

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // update the mirror for one accepted request and queue its result
        function void note_request(logic op, logic [ADDR_W-1:0] addr,
                                   logic [SIZE_W-1:0] size);
            alloc_result_t r;
            int i;
            int j;
            int hit;
            logic [SIZE_W-1:0] best_size;
            logic [63:0] sum;
            hit = -1;
            if (op == OP_INSERT) begin
                if (live_count >= TABLE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    for (i = live_count; i > 0; i--) begin
                        live_addr[i] = live_addr[i-1];
                        live_size[i] = live_size[i-1];
                    end
                    live_addr[0] = addr;
                    live_size[0] = size;
                    live_count++;
                    r.status = STAT_INSERTED;
                end
            end else begin
                for (i = 0; i < live_count && hit < 0; i++)
                    if (live_addr[i] == addr) hit = i;
                if (hit < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    for (j = hit; j + 1 < live_count; j++) begin
                        live_addr[j] = live_addr[j+1];
                        live_size[j] = live_size[j+1];
                    end
                    live_count--;
                    r.status = STAT_REMOVED;
                end
            end
            // newest entry wins a tie for the largest block
            r.largest_addr = '0;
            best_size = '0;
            sum = '0;
            for (i = 0; i < live_count; i++) begin
                if (i == 0 || live_size[i] > best_size) begin
                    best_size = live_size[i];
                    r.largest_addr = live_addr[i];
                end
                sum += live_size[i];
            end
            r.total_bytes = sum[TOTAL_W-1:0];
            r.live_entries = live_count[LIVE_W-1:0];
            expected_results.push_back(r);
        endfunction

        // compare one accepted result with the oldest prediction
        task check_result(logic [M_DATA_W-1:0] data);
            alloc_result_t got;
            alloc_result_t want;
            got.status       = data[STATUS_W-1:0];
            got.largest_addr = data[STATUS_W +: ADDR_W];
            got.total_bytes  = data[STATUS_W+ADDR_W +: TOTAL_W];
            got.live_entries = data[STATUS_W+ADDR_W+TOTAL_W +: LIVE_W];
            results_seen++;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result status=%0d", got.status));
            end else begin
                want = expected_results.pop_front();
                if (got.status != want.status)
                    report($sformatf("result %0d status %0d, want %0d",
                                     results_seen, got.status, want.status));
                if (got.largest_addr != want.largest_addr)
                    report($sformatf("result %0d largest addr %h, want %h",
                                     results_seen, got.largest_addr, want.largest_addr));
                if (got.total_bytes != want.total_bytes)
                    report($sformatf("result %0d total bytes %0d, want %0d",
                                     results_seen, got.total_bytes, want.total_bytes));
                if (got.live_entries != want.live_entries)
                    report($sformatf("result %0d live entries %0d, want %0d",
                                     results_seen, got.live_entries, want.live_entries));
            end
        endtask
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    alloc_scoreboard sb = new();
    logic        quiet_phase = 1'b0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned cycle_count = 0;

    allocation_tracking_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one long receiver hold-off, counted in cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else if (sb.results_seen == HOLD_AT && !hold_done) begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    // result side: check and random stalls
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet_phase || ($urandom_range(99) >= 26);
            end
        end
    end

    // offer one request and wait for its transaction
    task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr,
                                input logic [SIZE_W-1:0] size);
        if (!quiet_phase) begin
            while ($urandom_range(99) < 26) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tdata <= {{(S_DATA_W-S_BITS){1'b0}}, size, addr, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, addr, size);
    endtask

    localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
    localparam logic [ADDR_W-1:0] ADDR_DUP  = 64'hA5A5_0000_DEAD_BEE0;
    localparam logic [SIZE_W-1:0] SIZE_MAX  = '1;

    initial begin
        logic [ADDR_W-1:0] addr_pool [8];
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic op;
        int insert_pct;
        int pick;
        int seg;
        int k;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty delete, zero sizes, duplicates, ties, full table
        send_request(OP_DELETE, '0, SIZE_MAX);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, ADDR_ONES, '0);
        send_request(OP_INSERT, ADDR_DUP, SIZE_MAX);
        send_request(OP_INSERT, ADDR_DUP, SIZE_MAX);
        send_request(OP_DELETE, ADDR_DUP, '0);
        send_request(OP_DELETE, 64'h0000_0000_0000_1234, '0);
        for (k = 0; k < 13; k++)
            send_request(OP_INSERT, 64'h8000_0000_0000_1000 + k, SIZE_MAX - k);
        send_request(OP_INSERT, 64'h5555_5555_5555_5555, SIZE_MAX);
        send_request(OP_DELETE, ADDR_ONES, '0);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_DELETE, ADDR_DUP, '0);

        // random: phases with different insert weights fill and drain the table
        for (k = 0; k < 8; k++) addr_pool[k] = {$urandom, $urandom};
        addr_pool[0] = '0;
        addr_pool[1] = ADDR_ONES;
        for (seg = 0; seg < 19; seg++) begin
            case (seg % 5)
                0: insert_pct = 85;
                1: insert_pct = 30;
                2: insert_pct = 95;
                3: insert_pct = 50;
                default: insert_pct = 15;
            endcase
            quiet_phase = (seg >= 12 && seg < 15);
            for (k = 0; k < 100; k++) begin
                op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
                pick = $urandom_range(99);
                if (pick < 40 && sb.live_count > 0)
                    addr = sb.live_addr[$urandom_range(sb.live_count - 1)];
                else if (pick < 75)
                    addr = addr_pool[$urandom_range(7)];
                else
                    addr = {$urandom, $urandom};
                pick = $urandom_range(99);
                if (pick < 40)      size = $urandom;
                else if (pick < 65) size = $urandom_range(3);
                else if (pick < 78) size = SIZE_MAX;
                else if (pick < 88) size = '0;
                else                size = $urandom_range(4096);
                send_request(op, addr, size);
            end
        end
        quiet_phase = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then let any trailing work settle
        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ allocation_tracking_table.f @@
hw/rtl/att_pkg.sv
hw/rtl/att_table.sv
hw/rtl/att_alu.sv
hw/rtl/allocation_tracking_table.sv
dv/tb.sv
